[src/jsd_pkg.sv]
package jsd_pkg;

  // field widths
  localparam int JOINT_W    = 4;
  localparam int ERR_W      = 24;
  localparam int INTERVAL_W = 24;
  localparam int ACC_W      = 32;
  localparam int CFG_IDX_W  = 4;

  // divider widths: |avg| * 10000 fits 37 bits, 7 * interval fits 27 bits
  localparam int NUM_W     = 37;
  localparam int PROD_W    = NUM_W + 1;
  localparam int DIVISOR_W = INTERVAL_W + 3;
  localparam int SUM_W     = NUM_W + 2;
  localparam int CNT_W     = $clog2(NUM_W);

  // 1 / (700 * t[s]) in Q8 becomes avg * 10000 / (7 * interval_us)
  localparam logic [13:0] RATE_SCALE = 14'd10000;

  // 1.0 in Q15.8
  localparam logic signed [ERR_W:0] MOVE_LIMIT = 25'sd256;

  // 2 s in microseconds
  localparam logic [INTERVAL_W-1:0] LONG_INTERVAL = 24'd2000000;

  // what the back end has to do with an item
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CLEAR,
    KIND_ADD
  } kind_t;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    kind_t                    kind;
    logic signed [ERR_W-1:0]  avg;
    logic [INTERVAL_W-1:0]    interval;
    logic                     enabled;
    logic                     opening;
    logic signed [ACC_W-1:0]  threshold;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_SUM,
    S_DONE
  } back_state_t;

endpackage

[src/jsd_front.sv]
module jsd_front #(
  parameter int JOINT_COUNT = 8
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  input  logic [jsd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic signed [jsd_pkg::ACC_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [jsd_pkg::JOINT_W-1:0]            joint_index,
  input  logic signed [jsd_pkg::ERR_W-1:0]       joint_error,
  input  logic [jsd_pkg::INTERVAL_W-1:0]         interval_us,
  input  logic                                   joint_enabled,
  output logic                                   push,
  output jsd_pkg::entry_t                        push_entry,
  input  logic                                   push_ready
);

  localparam int JW        = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int JOINT_W   = jsd_pkg::JOINT_W;
  localparam int CFG_IDX_W = jsd_pkg::CFG_IDX_W;
  localparam int ERR_W     = jsd_pkg::ERR_W;
  localparam int ACC_W     = jsd_pkg::ACC_W;
  localparam logic [JOINT_W-1:0]   JOINT_LIMIT = JOINT_W'(JOINT_COUNT);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = CFG_IDX_W'(JOINT_COUNT);

  logic signed [ACC_W-1:0] threshold [JOINT_COUNT];
  logic signed [ERR_W-1:0] prev_avg  [JOINT_COUNT];

  logic                    joint_valid;
  logic [JW-1:0]           sel;
  logic signed [ERR_W-1:0] prev;
  logic signed [ACC_W-1:0] thr;
  logic signed [ERR_W:0]   sum;
  logic signed [ERR_W-1:0] avg;
  logic signed [ERR_W:0]   diff;
  logic                    still;
  logic                    opening;
  logic                    toward;
  jsd_pkg::kind_t          kind;

  // look up the joint's stored average and threshold
  always_comb begin
    joint_valid = joint_index < JOINT_LIMIT;
    sel         = joint_index[JW-1:0];
    prev        = joint_valid ? prev_avg[sel] : '0;
    thr         = joint_valid ? threshold[sel] : '0;
  end

  // floor average, movement and sign tests
  always_comb begin
    sum     = {prev[ERR_W-1], prev} + {joint_error[ERR_W-1], joint_error};
    avg     = sum[ERR_W:1];
    diff    = {avg[ERR_W-1], avg} - {prev[ERR_W-1], prev};
    still   = (diff < jsd_pkg::MOVE_LIMIT) && (diff > -jsd_pkg::MOVE_LIMIT);
    opening = thr > 32'sd0;
    toward  = opening ? (avg > 24'sd0) : (avg < 24'sd0);
    if (!joint_valid) begin
      kind = jsd_pkg::KIND_NONE;
    end else if (still || !toward) begin
      kind = jsd_pkg::KIND_CLEAR;
    end else begin
      kind = jsd_pkg::KIND_ADD;
    end
  end

  // item handed to the queue
  always_comb begin
    push_entry.joint     = joint_index;
    push_entry.kind      = kind;
    push_entry.avg       = avg;
    push_entry.interval  = interval_us;
    push_entry.enabled   = joint_enabled;
    push_entry.opening   = opening;
    push_entry.threshold = thr;
  end

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  // thresholds and stored averages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        threshold[i] <= '0;
        prev_avg[i]  <= '0;
      end
    end else begin
      if (cfg_valid && (cfg_index < CFG_LIMIT)) begin
        threshold[cfg_index[JW-1:0]] <= cfg_data;
      end
      if (push && joint_valid) begin
        prev_avg[sel] <= avg;
      end
    end
  end

endmodule

[src/jsd_fifo.sv]
module jsd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jsd_pkg::entry_t push_entry,
  output logic            push_ready,
  input  logic            pop,
  output jsd_pkg::entry_t pop_entry,
  output logic            pop_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  jsd_pkg::entry_t slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign push_ready = count != FULL;
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= FULL)
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("pop from empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != FULL) || pop)
    else $error("push into full queue");

endmodule

[src/jsd_back.sv]
module jsd_back #(
  parameter int JOINT_COUNT = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pop_valid,
  input  jsd_pkg::entry_t                    pop_entry,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [jsd_pkg::JOINT_W-1:0]        result_joint,
  output logic signed [jsd_pkg::ACC_W-1:0]   smoothed_error,
  output logic                               blocked,
  output logic                               no_threshold
);

  localparam int JW        = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int ACC_W     = jsd_pkg::ACC_W;
  localparam int ERR_W     = jsd_pkg::ERR_W;
  localparam int NUM_W     = jsd_pkg::NUM_W;
  localparam int PROD_W    = jsd_pkg::PROD_W;
  localparam int DIVISOR_W = jsd_pkg::DIVISOR_W;
  localparam int SUM_W     = jsd_pkg::SUM_W;
  localparam int CNT_W     = jsd_pkg::CNT_W;

  jsd_pkg::back_state_t    state;
  jsd_pkg::back_state_t    state_next;
  jsd_pkg::entry_t         cur;
  logic signed [ACC_W-1:0] acc [JOINT_COUNT];
  logic [NUM_W-1:0]        num;
  logic [DIVISOR_W-1:0]    divisor;
  logic [DIVISOR_W-1:0]    rem;
  logic [CNT_W-1:0]        cnt;
  logic                    neg;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_new;

  logic [JW-1:0]           idx;
  logic                    div_needed;
  logic                    out_free;
  logic                    acc_we;
  logic                    out_load;
  logic [ERR_W-1:0]        avg_mag;
  logic [PROD_W-1:0]       product;
  logic [DIVISOR_W-1:0]    divisor_calc;
  logic signed [ACC_W-1:0] base_calc;
  logic [DIVISOR_W:0]      rem_sh;
  logic [DIVISOR_W:0]      rem_sub;
  logic                    fits;
  logic signed [SUM_W-1:0] q_mag;
  logic signed [SUM_W-1:0] q_signed;
  logic signed [SUM_W-1:0] total;
  logic signed [ACC_W-1:0] sat;
  logic                    over_thr;

  assign idx        = cur.joint[JW-1:0];
  assign div_needed = (cur.kind == jsd_pkg::KIND_ADD) && (cur.interval != '0);
  assign out_free   = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      jsd_pkg::S_IDLE: if (pop_valid) state_next = jsd_pkg::S_LOAD;
      jsd_pkg::S_LOAD: state_next = div_needed ? jsd_pkg::S_DIV : jsd_pkg::S_SUM;
      jsd_pkg::S_DIV:  if (cnt == '0) state_next = jsd_pkg::S_SUM;
      jsd_pkg::S_SUM:  state_next = jsd_pkg::S_DONE;
      jsd_pkg::S_DONE: if (out_free) state_next = jsd_pkg::S_IDLE;
      default:         state_next = jsd_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop      = (state == jsd_pkg::S_IDLE) && pop_valid;
    acc_we   = (state == jsd_pkg::S_SUM) && (cur.kind != jsd_pkg::KIND_NONE);
    out_load = (state == jsd_pkg::S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand setup: |avg| * 10000 over 7 * interval
  always_comb begin
    avg_mag      = cur.avg[ERR_W-1] ? (~cur.avg + 1'b1) : cur.avg;
    product      = PROD_W'(avg_mag) * PROD_W'(jsd_pkg::RATE_SCALE);
    divisor_calc = {cur.interval, 3'b000} - {3'b000, cur.interval};
    if ((cur.kind == jsd_pkg::KIND_ADD) && (cur.interval <= jsd_pkg::LONG_INTERVAL)) begin
      base_calc = acc[idx];
    end else begin
      base_calc = '0;
    end
  end

  // one restoring division step, one quotient bit
  always_comb begin
    rem_sh  = {rem, num[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    fits    = rem_sh >= {1'b0, divisor};
  end

  // signed sum with saturation to the accumulator range
  always_comb begin
    q_mag    = {2'b00, num};
    q_signed = neg ? -q_mag : q_mag;
    total    = q_signed + {{(SUM_W - ACC_W){base[ACC_W-1]}}, base};
    if (total[SUM_W-1:ACC_W-1] == '0 || total[SUM_W-1:ACC_W-1] == '1) begin
      sat = total[ACC_W-1:0];
    end else if (total[SUM_W-1]) begin
      sat = {1'b1, {(ACC_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(ACC_W - 1){1'b1}}};
    end
  end

  // blocked test against the signed threshold
  assign over_thr = cur.opening ? (acc_new > cur.threshold) : (acc_new < cur.threshold);

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      jsd_pkg::S_IDLE: begin
        if (pop) cur <= pop_entry;
      end
      jsd_pkg::S_LOAD: begin
        num     <= div_needed ? product[NUM_W-1:0] : '0;
        divisor <= divisor_calc;
        rem     <= '0;
        cnt     <= CNT_W'(NUM_W - 1);
        neg     <= cur.avg[ERR_W-1];
        base    <= base_calc;
      end
      jsd_pkg::S_DIV: begin
        rem <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        num <= {num[NUM_W-2:0], fits};
        cnt <= cnt - 1'b1;
      end
      jsd_pkg::S_SUM: begin
        acc_new <= sat;
      end
      default: begin
      end
    endcase
  end

  // per-joint accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        acc[i] <= '0;
      end
    end else if (acc_we) begin
      acc[idx] <= sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_joint   <= cur.joint;
      smoothed_error <= acc_new;
      blocked        <= cur.enabled && (cur.kind != jsd_pkg::KIND_NONE) && over_thr;
      no_threshold   <= cur.kind == jsd_pkg::KIND_NONE;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == jsd_pkg::S_DIV |-> divisor != '0)
    else $error("divide step with zero divisor");

  a_none_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_threshold |-> (smoothed_error == '0) && !blocked)
    else $error("joint without threshold reports a value");

  a_sum_then_done: assert property (@(posedge clk) disable iff (rst)
    state == jsd_pkg::S_SUM |=> state == jsd_pkg::S_DONE)
    else $error("sum not followed by result stage");

endmodule

[src/joint_stall_detector.sv]
// Per-joint stall detector. Each item carries one joint's error sample, the
// interval since its last sample and an enabled flag; each item gives exactly
// one result, in order. The front end smooths the error, classifies the item
// and takes a new item every cycle while the queue has room. The back end
// works one queued item at a time: items that need an increment pass through
// queue read, load, 37 steps of the restoring divider at one quotient bit a
// cycle, sum and result; all others skip the divider. Thresholds are written
// through the cfg port, index i for joint i; writes are taken every cycle
// and should happen while idle.
module joint_stall_detector #(
  parameter int JOINT_COUNT = 8,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic signed [jsd_pkg::ACC_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [jsd_pkg::JOINT_W-1:0]        joint_index,
  input  logic signed [jsd_pkg::ERR_W-1:0]   joint_error,
  input  logic [jsd_pkg::INTERVAL_W-1:0]     interval_us,
  input  logic                               joint_enabled,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [jsd_pkg::JOINT_W-1:0]        result_joint,
  output logic signed [jsd_pkg::ACC_W-1:0]   smoothed_error,
  output logic                               blocked,
  output logic                               no_threshold
);

  logic            push;
  logic            push_ready;
  jsd_pkg::entry_t push_entry;
  logic            pop;
  logic            pop_valid;
  jsd_pkg::entry_t pop_entry;

  assign cfg_ready = 1'b1;

  // smoothing and classification
  jsd_front #(
    .JOINT_COUNT(JOINT_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .joint_index  (joint_index),
    .joint_error  (joint_error),
    .interval_us  (interval_us),
    .joint_enabled(joint_enabled),
    .push         (push),
    .push_entry   (push_entry),
    .push_ready   (push_ready)
  );

  // queue between front and back
  jsd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .push_ready(push_ready),
    .pop       (pop),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid)
  );

  // divider, accumulators and result register
  jsd_back #(
    .JOINT_COUNT(JOINT_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_entry     (pop_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_joint  (result_joint),
    .smoothed_error(smoothed_error),
    .blocked       (blocked),
    .no_threshold  (no_threshold)
  );

endmodule

[tb/sv/joint_stall_detector_test.sv]
`timescale 1ns / 1ps

module joint_stall_detector_test;

  localparam int JOINTS       = 8;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 246;
  localparam int SETTLE       = 60;
  localparam int LONG_HOLD    = 400;
  localparam int WATCHDOG_MAX = 5000;
  localparam longint ACC_MAX  = 64'sd2147483647;
  localparam longint ACC_MIN  = -64'sd2147483648;

  typedef struct {
    logic [jsd_pkg::JOINT_W-1:0]      joint;
    logic signed [jsd_pkg::ERR_W-1:0] err;
    logic [jsd_pkg::INTERVAL_W-1:0]   interval;
    logic                             enabled;
  } sample_t;

  typedef struct {
    logic [jsd_pkg::JOINT_W-1:0]      joint;
    logic signed [jsd_pkg::ACC_W-1:0] acc;
    logic                             blocked;
    logic                             no_thr;
  } report_t;

  typedef struct {
    logic [jsd_pkg::CFG_IDX_W-1:0]    idx;
    logic signed [jsd_pkg::ACC_W-1:0] data;
  } thr_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [jsd_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic signed [jsd_pkg::ACC_W-1:0]   cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [jsd_pkg::JOINT_W-1:0]        joint_index = '0;
  logic signed [jsd_pkg::ERR_W-1:0]   joint_error = '0;
  logic [jsd_pkg::INTERVAL_W-1:0]     interval_us = '0;
  logic                               joint_enabled = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [jsd_pkg::JOINT_W-1:0]        result_joint;
  logic signed [jsd_pkg::ACC_W-1:0]   smoothed_error;
  logic                               blocked;
  logic                               no_threshold;

  // predictor state
  logic signed [jsd_pkg::ERR_W-1:0] avg_model [JOINTS];
  logic signed [jsd_pkg::ACC_W-1:0] acc_model [JOINTS];
  logic signed [jsd_pkg::ACC_W-1:0] thr_model [JOINTS];

  // stimulus bookkeeping
  sample_t    sample_q [$];
  thr_write_t thr_write_q [$];
  report_t    pending_reports [$];
  int         error_count = 0;
  int         ramp [JOINTS];
  int         thr_plan [JOINTS];

  // sender and receiver pacing
  int burst_left = 0;
  int gap_left = 0;
  int ready_mode = 0;
  int ready_mode_left = 0;
  int ready_tick = 0;
  int hold_left = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;
  int idle_cycles = 0;

  joint_stall_detector i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .joint_index    (joint_index),
    .joint_error    (joint_error),
    .interval_us    (interval_us),
    .joint_enabled  (joint_enabled),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_joint   (result_joint),
    .smoothed_error (smoothed_error),
    .blocked        (blocked),
    .no_threshold   (no_threshold)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // expected report for one accepted sample, updates the joint state
  function automatic report_t predict_report(sample_t s);
    report_t                          r;
    logic signed [jsd_pkg::ERR_W-1:0] prev;
    logic signed [jsd_pkg::ERR_W:0]   sum;
    logic signed [jsd_pkg::ERR_W-1:0] avg;
    longint                           move;
    longint                           base;
    longint                           acc;
    bit                               opening;
    int                               j;
    r.joint = s.joint;
    r.acc = '0;
    r.blocked = 1'b0;
    r.no_thr = 1'b1;
    if (s.joint >= JOINTS) return r;
    j = s.joint;
    prev = avg_model[j];
    sum = prev + s.err;
    avg = sum >>> 1;
    move = longint'(avg) - longint'(prev);
    if (move < 0) move = -move;
    opening = thr_model[j] > 0;
    // small movement clears, matching sign accumulates, otherwise clear
    if (move < 256) begin
      acc = 0;
    end else if ((opening && avg > 0) || (!opening && avg < 0)) begin
      base = (s.interval > jsd_pkg::LONG_INTERVAL) ? 0 : longint'(acc_model[j]);
      if (s.interval != 0)
        acc = base + (longint'(avg) * 10000) / (longint'(s.interval) * 7);
      else
        acc = base;
    end else begin
      acc = 0;
    end
    if (acc > ACC_MAX) acc = ACC_MAX;
    if (acc < ACC_MIN) acc = ACC_MIN;
    acc_model[j] = acc[jsd_pkg::ACC_W-1:0];
    avg_model[j] = avg;
    r.acc = acc_model[j];
    r.no_thr = 1'b0;
    r.blocked = s.enabled && ((opening && acc_model[j] > thr_model[j]) ||
                              (!opening && acc_model[j] < thr_model[j]));
    return r;
  endfunction

  function automatic logic [jsd_pkg::INTERVAL_W-1:0] pick_interval();
    case ($urandom_range(7))
      0: return '0;
      1: return 24'd1;
      2: return jsd_pkg::LONG_INTERVAL;
      3: return jsd_pkg::LONG_INTERVAL + 24'd1;
      4: return 24'($urandom_range(2000001, 16777215));
      5: return '1;
      default: return 24'($urandom);
    endcase
  endfunction

  // mostly steady trends per joint in the direction of its threshold
  function automatic sample_t make_sample();
    sample_t s;
    int      pick;
    int      j;
    int      dir;
    pick = $urandom_range(99);
    s.enabled = ($urandom_range(9) != 0);
    if (pick < 10) begin
      s.joint = 4'($urandom_range(JOINTS, 15));
      s.err = 24'($urandom);
      s.interval = pick_interval();
      s.enabled = 1'($urandom);
    end else if (pick < 30) begin
      s.joint = 4'($urandom_range(JOINTS - 1));
      s.err = 24'($urandom);
      s.interval = pick_interval();
      s.enabled = 1'($urandom);
    end else begin
      j = $urandom_range(JOINTS - 1);
      dir = (thr_plan[j] > 0) ? 1 : -1;
      case ($urandom_range(9))
        0, 1: ;
        2: ramp[j] -= dir * $urandom_range(600, 20000);
        default: ramp[j] += dir * $urandom_range(600, 60000);
      endcase
      if (ramp[j] > 8388607 || ramp[j] < -8388608)
        ramp[j] = dir * $urandom_range(0, 1000);
      s.joint = 4'(j);
      s.err = 24'(ramp[j]);
      s.interval = 24'($urandom_range(500, 30000));
    end
    return s;
  endfunction

  task automatic push_sample(int j, int e, int dt, bit en);
    sample_t s;
    s.joint = 4'(j);
    s.err = 24'(e);
    s.interval = 24'(dt);
    s.enabled = en;
    sample_q.push_back(s);
  endtask

  task automatic write_thr(int idx, int data);
    thr_write_t w;
    w.idx = 4'(idx);
    w.data = data;
    if (idx < JOINTS) thr_plan[idx] = data;
    thr_write_q.push_back(w);
  endtask

  // register writes go out only once everything has drained
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || pending_reports.size() != 0 ||
           thr_write_q.size() != 0 || cfg_valid);
    repeat (SETTLE) @(negedge clk);
  endtask

  // threshold write channel
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < JOINTS)
        thr_model[cfg_index] = cfg_data;
      if (!cfg_valid || cfg_ready) begin
        if (thr_write_q.size() != 0) begin
          cfg_index <= thr_write_q[0].idx;
          cfg_data <= thr_write_q[0].data;
          cfg_valid <= 1'b1;
          void'(thr_write_q.pop_front());
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // sample driver, bursts with random gaps
  always @(posedge clk) begin
    sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s.joint = joint_index;
        s.err = joint_error;
        s.interval = interval_us;
        s.enabled = joint_enabled;
        pending_reports.push_back(predict_report(s));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          s = sample_q.pop_front();
          joint_index <= s.joint;
          joint_error <= s.err;
          interval_us <= s.interval;
          joint_enabled <= s.enabled;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            case ($urandom_range(3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(20, 60);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall pattern, with one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (ready_mode_left == 0) begin
        ready_mode = $urandom_range(3);
        ready_mode_left = $urandom_range(32, 256);
      end else begin
        ready_mode_left--;
      end
      ready_tick++;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= ($urandom_range(3) == 0);
        default: out_ready <= ((ready_tick % 7) < 4);
      endcase
    end
  end

  // report checker
  always @(posedge clk) begin
    report_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report joint %0d acc %0d blocked %0b no_thr %0b",
                 $time, result_joint, smoothed_error, blocked, no_threshold);
        error_count++;
      end else begin
        e = pending_reports.pop_front();
        if (result_joint !== e.joint) begin
          $display("%0t: result_joint expected %0d actual %0d", $time, e.joint, result_joint);
          error_count++;
        end
        if (smoothed_error !== e.acc) begin
          $display("%0t: smoothed_error joint %0d expected %0d actual %0d",
                   $time, e.joint, e.acc, smoothed_error);
          error_count++;
        end
        if (blocked !== e.blocked) begin
          $display("%0t: blocked joint %0d expected %0b actual %0b",
                   $time, e.joint, e.blocked, blocked);
          error_count++;
        end
        if (no_threshold !== e.no_thr) begin
          $display("%0t: no_threshold joint %0d expected %0b actual %0b",
                   $time, e.joint, e.no_thr, no_threshold);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer while work is outstanding
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready) ||
        (sample_q.size() == 0 && !in_valid && pending_reports.size() == 0 &&
         thr_write_q.size() == 0 && !cfg_valid)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int p;
    int j;
    int k;
    for (j = 0; j < JOINTS; j++) begin
      avg_model[j] = '0;
      acc_model[j] = '0;
      thr_model[j] = '0;
      ramp[j] = 0;
      thr_plan[j] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed thresholds: both signs, zero, the extremes, unused indexes
    write_thr(0, 1280);
    write_thr(1, -1280);
    write_thr(2, 0);
    write_thr(3, 32'h7fffffff);
    write_thr(4, 32'h80000000);
    write_thr(5, 1);
    write_thr(6, -1);
    write_thr(7, 1000);
    for (k = JOINTS; k < 16; k++) write_thr(k, $urandom);
    wait_idle();

    // opening joint: accumulate, zero interval, long interval, saturation
    push_sample(0, 8388607, 1000, 1);
    push_sample(0, 8388607, 0, 1);
    push_sample(0, 8388607, 3000000, 1);
    push_sample(0, 8388607, 16777215, 0);
    push_sample(0, 8388607, 1, 1);
    push_sample(0, 8388607, 1, 1);
    // sign against an opening threshold clears
    push_sample(0, -8388608, 1000, 1);
    // closing joint: saturate low, interval at and just past two seconds
    push_sample(1, -8388608, 1, 1);
    push_sample(1, -8388608, 2000000, 0);
    push_sample(1, -8388608, 2000001, 1);
    // floor halving of a tiny negative error, small movement clears
    push_sample(2, -1, 500, 1);
    push_sample(2, -4096, 500, 1);
    push_sample(2, 4096, 500, 1);
    // thresholds at the extremes can never be passed
    push_sample(3, 8388607, 7, 1);
    push_sample(4, -8388608, 7, 1);
    push_sample(5, 255, 1000, 1);
    push_sample(5, 1024, 1000, 1);
    push_sample(6, 300000, 20000, 1);
    push_sample(6, -300000, 20000, 1);
    push_sample(7, 100000, 700, 1);
    // joints without a threshold
    push_sample(8, 8388607, 16777215, 1);
    push_sample(15, -8388608, 0, 0);
    push_sample(9, 0, 1, 1);
    wait_idle();

    for (p = 0; p < PHASES; p++) begin
      for (j = 0; j < JOINTS; j++) begin
        if (p == 0) begin
          case (j % 4)
            0: write_thr(j, 32'h7fffffff);
            1: write_thr(j, 32'h80000000);
            2: write_thr(j, 1);
            default: write_thr(j, -1);
          endcase
        end else begin
          case ($urandom_range(5))
            0: write_thr(j, $urandom);
            1: write_thr(j, $urandom_range(256, 1 << 22));
            2: write_thr(j, -$urandom_range(256, 1 << 22));
            3: write_thr(j, 0);
            default: write_thr(j, ($urandom_range(1) ? 1 : -1) *
                                  $urandom_range(1 << 12, 1 << 18));
          endcase
        end
      end
      write_thr($urandom_range(JOINTS, 15), $urandom);
      wait_idle();
      // one phase starts with a long result hold while samples keep coming
      if (p == 1) long_hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) sample_q.push_back(make_sample());
      wait_idle();
    end

    if (pending_reports.size() != 0) error_count++;
    if (error_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
src/jsd_pkg.sv
src/jsd_front.sv
src/jsd_fifo.sv
src/jsd_back.sv
src/joint_stall_detector.sv
tb/sv/joint_stall_detector_test.sv
